// ===== rtl/sdc_pkg.sv =====
// Shared types and constants of the signal dispatch controller.
// No dependencies; every other file of the block imports this package.
package sdc_pkg;

  // field widths of the command and result words
  localparam int CMD_W  = 3;
  localparam int SIG_W  = 5;
  localparam int KIND_W = 2;
  localparam int MASK_W = 32;
  localparam int ADDR_W = 64;
  localparam int OC_W   = 2;

  // width of the pending, block and fatal bitmaps
  localparam int MAP_BITS = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_RAISE      = 3'd0,
    CMD_SET_ACTION = 3'd1,
    CMD_BLOCK      = 3'd2,
    CMD_UNBLOCK    = 3'd3,
    CMD_SET_MASK   = 3'd4,
    CMD_SUSPEND    = 3'd5,
    CMD_DELIVER    = 3'd6,
    CMD_RESTORE    = 3'd7
  } cmd_t;

  // disposition kinds
  localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HANDLER = 2'd2;

  // deliver outcomes
  localparam logic [OC_W-1:0] OC_NONE      = 2'd0;
  localparam logic [OC_W-1:0] OC_HANDLER   = 2'd1;
  localparam logic [OC_W-1:0] OC_TERMINATE = 2'd2;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // one command word as held in the input register
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SIG_W-1:0]  signal_number;
    logic [KIND_W-1:0] action_kind;
    logic              reset_on_delivery;
    logic [MASK_W-1:0] handler_mask_in;
    logic [ADDR_W-1:0] handler_address_in;
    logic [MASK_W-1:0] mask_value;
  } item_t;

  // one result word as held in the output register
  typedef struct packed {
    logic              status;
    logic [OC_W-1:0]   outcome;
    logic [SIG_W-1:0]  delivered_signal;
    logic [ADDR_W-1:0] handler_address_out;
    logic [MASK_W-1:0] reported_mask;
    logic [KIND_W-1:0] old_action_kind;
    logic              old_reset_flag;
    logic [MASK_W-1:0] old_handler_mask;
    logic              wake_ready;
  } res_t;

  // deliver selection handed from the picker to the top level
  typedef struct packed {
    logic                found;
    logic [SIG_W-1:0]    idx;
    logic [MAP_BITS-1:0] onehot;
    logic [MAP_BITS-1:0] clear;
  } sel_t;

endpackage

// ===== rtl/sdc_cmd_if.sv =====
// Command channel of the signal dispatch controller: valid/ready plus one word.
// Depends on sdc_pkg for the field widths.
interface sdc_cmd_if import sdc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIG_W-1:0]  signal_number;
  logic [KIND_W-1:0] action_kind;
  logic              reset_on_delivery;
  logic [MASK_W-1:0] handler_mask_in;
  logic [ADDR_W-1:0] handler_address_in;
  logic [MASK_W-1:0] mask_value;

  modport source (
    output valid, command, signal_number, action_kind, reset_on_delivery,
           handler_mask_in, handler_address_in, mask_value,
    input  ready
  );

  modport sink (
    input  valid, command, signal_number, action_kind, reset_on_delivery,
           handler_mask_in, handler_address_in, mask_value,
    output ready
  );

endinterface

// ===== rtl/sdc_res_if.sv =====
// Result channel of the signal dispatch controller: valid/ready plus one word.
// Depends on sdc_pkg for the field widths.
interface sdc_res_if import sdc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              status;
  logic [OC_W-1:0]   outcome;
  logic [SIG_W-1:0]  delivered_signal;
  logic [ADDR_W-1:0] handler_address_out;
  logic [MASK_W-1:0] reported_mask;
  logic [KIND_W-1:0] old_action_kind;
  logic              old_reset_flag;
  logic [MASK_W-1:0] old_handler_mask;
  logic              wake_ready;

  modport source (
    output valid, status, outcome, delivered_signal, handler_address_out,
           reported_mask, old_action_kind, old_reset_flag, old_handler_mask,
           wake_ready,
    input  ready
  );

  modport sink (
    input  valid, status, outcome, delivered_signal, handler_address_out,
           reported_mask, old_action_kind, old_reset_flag, old_handler_mask,
           wake_ready,
    output ready
  );

endinterface

// ===== rtl/signal_dispatch_controller.sv =====
// Signal dispatch controller top level: input register, single-pass command
// logic, result register. Depends on sdc_pkg, sdc_cmd_if, sdc_res_if, sdc_pick.
//
// Usage:
//   in_word  - command words (raise, set action, mask updates, suspend,
//              deliver, restore), taken when valid and ready are both high.
//   out_word - exactly one result word per command, in command order.
//   cfg_wr_en / cfg_wr_data - write the fatal-default mask; write only while
//              no command is in flight.
// Path: a taken word waits in the input register until the result register can
//   accept; it then executes and its result is registered in the result register.
// Throughput: one command per cycle while the result is taken; the pending/mask
//   update, the priority pick of the deliver scan and the single table access
//   all sit in the one stage between the input and result registers.
// Reset (rst_n low, synchronous): pending, masks, stash, fatal mask and the
//   disposition table read as all zero right after reset; no sweep is needed.
// Stall: when out_word.ready is low the result word holds, one more command
//   waits in the input register, and in_word.ready drops until space frees.
module signal_dispatch_controller import sdc_pkg::*; #(
  parameter int SIGNAL_COUNT = 32,
  parameter int KILL_INDEX   = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  sdc_cmd_if.sink             in_word,
  sdc_res_if.source           out_word,
  input  logic                cfg_wr_en,
  input  logic [MASK_W-1:0]   cfg_wr_data
);

  localparam int TBL_DEPTH = (SIGNAL_COUNT < MAP_BITS) ? SIGNAL_COUNT : MAP_BITS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [MAP_BITS-1:0] KILL_BIT   = MAP_BITS'(1) << KILL_INDEX;
  localparam logic [SIG_W-1:0]    KILL_SIG   = SIG_W'(KILL_INDEX);
  localparam logic [MAP_BITS:0]   RANGE_ONES =
      ((MAP_BITS+1)'(1) << TBL_DEPTH) - (MAP_BITS+1)'(1);
  localparam logic [MAP_BITS-1:0] SCAN_MASK  = RANGE_ONES[MAP_BITS-1:0] & ~MAP_BITS'(1);

  // handshake registers
  logic  iv_r;
  item_t item_r;
  logic  ov_r;
  res_t  res_r;
  res_t  res_nxt;
  logic  exec;

  // controller state
  logic [MAP_BITS-1:0] fatal_r;
  logic [MAP_BITS-1:0] pend_r, pend_nxt;
  logic [MAP_BITS-1:0] block_r, block_nxt;
  logic [MAP_BITS-1:0] stash_r, stash_nxt;
  logic                stash_v_r, stash_v_nxt;

  // disposition table
  logic [KIND_W-1:0] kind_r     [TBL_DEPTH];
  logic              once_r     [TBL_DEPTH];
  logic              ent_v_r    [TBL_DEPTH];
  logic [MASK_W-1:0] hmask_r    [TBL_DEPTH];
  logic [ADDR_W-1:0] entry_r    [TBL_DEPTH];

  logic [TBL_AW-1:0] tbl_idx;
  logic [KIND_W-1:0] rd_kind;
  logic              rd_once;
  logic [MASK_W-1:0] rd_hmask;
  logic [ADDR_W-1:0] rd_entry;
  logic              tbl_we_set;
  logic              tbl_we_revert;

  logic [MAP_BITS-1:0] dflt_vec;
  logic [MAP_BITS-1:0] hdl_vec;
  sel_t                sel;
  cmd_t                cmd;
  logic                sig_in_range;
  logic [MAP_BITS-1:0] sig_bit;
  logic [MAP_BITS-1:0] mval_nokill;

  // pipeline handshake
  assign exec          = iv_r && (!ov_r || out_word.ready);
  assign in_word.ready = !iv_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        iv_r <= 1'b1;
      end else if (exec) begin
        iv_r <= 1'b0;
      end
      if (exec) begin
        ov_r <= 1'b1;
      end else if (out_word.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      item_r.command            <= in_word.command;
      item_r.signal_number      <= in_word.signal_number;
      item_r.action_kind        <= in_word.action_kind;
      item_r.reset_on_delivery  <= in_word.reset_on_delivery;
      item_r.handler_mask_in    <= in_word.handler_mask_in;
      item_r.handler_address_in <= in_word.handler_address_in;
      item_r.mask_value         <= in_word.mask_value;
    end
    if (exec) res_r <= res_nxt;
  end

  assign out_word.valid               = ov_r;
  assign out_word.status              = res_r.status;
  assign out_word.outcome             = res_r.outcome;
  assign out_word.delivered_signal    = res_r.delivered_signal;
  assign out_word.handler_address_out = res_r.handler_address_out;
  assign out_word.reported_mask       = res_r.reported_mask;
  assign out_word.old_action_kind     = res_r.old_action_kind;
  assign out_word.old_reset_flag      = res_r.old_reset_flag;
  assign out_word.old_handler_mask    = res_r.old_handler_mask;
  assign out_word.wake_ready          = res_r.wake_ready;

  // per-signal kind flags for the deliver scan
  for (genvar i = 0; i < MAP_BITS; i++) begin : g_kind
    if (i < TBL_DEPTH) begin : g_on
      assign dflt_vec[i] = (kind_r[i] == KIND_DEFAULT);
      assign hdl_vec[i]  = (kind_r[i] == KIND_HANDLER);
    end else begin : g_off
      assign dflt_vec[i] = 1'b0;
      assign hdl_vec[i]  = 1'b0;
    end
  end

  sdc_pick #(
    .KILL_INDEX (KILL_INDEX),
    .SCAN_MASK  (SCAN_MASK)
  ) u_pick (
    .pending    (pend_r),
    .block      (block_r),
    .dflt_vec   (dflt_vec),
    .hdl_vec    (hdl_vec),
    .fatal_mask (fatal_r),
    .sel        (sel)
  );

  // one table access: chosen signal on deliver, addressed signal otherwise
  assign cmd     = cmd_t'(item_r.command);
  assign tbl_idx = (cmd == CMD_DELIVER) ? sel.idx[TBL_AW-1:0]
                                        : item_r.signal_number[TBL_AW-1:0];
  assign rd_kind  = kind_r[tbl_idx];
  assign rd_once  = once_r[tbl_idx];
  assign rd_hmask = ent_v_r[tbl_idx] ? hmask_r[tbl_idx] : '0;
  assign rd_entry = ent_v_r[tbl_idx] ? entry_r[tbl_idx] : '0;

  assign sig_in_range = ({1'b0, item_r.signal_number} < (SIG_W+1)'(TBL_DEPTH));
  assign sig_bit      = MAP_BITS'(1) << item_r.signal_number;
  assign mval_nokill  = item_r.mask_value & ~KILL_BIT;

  // command execution
  always_comb begin
    res_nxt       = '0;
    pend_nxt      = pend_r;
    block_nxt     = block_r;
    stash_nxt     = stash_r;
    stash_v_nxt   = stash_v_r;
    tbl_we_set    = 1'b0;
    tbl_we_revert = 1'b0;
    unique case (cmd)
      CMD_RAISE: begin
        if (item_r.signal_number != '0) begin
          if (!sig_in_range) res_nxt.status = STATUS_REJECT;
          else pend_nxt = pend_r | sig_bit;
        end
      end
      CMD_SET_ACTION: begin
        if (item_r.signal_number == '0 || item_r.signal_number == KILL_SIG ||
            !sig_in_range || item_r.action_kind > KIND_HANDLER) begin
          res_nxt.status = STATUS_REJECT;
        end else begin
          res_nxt.handler_address_out = rd_entry;
          res_nxt.old_action_kind     = rd_kind;
          res_nxt.old_reset_flag      = rd_once;
          res_nxt.old_handler_mask    = rd_hmask;
          tbl_we_set                  = 1'b1;
        end
      end
      CMD_BLOCK: begin
        res_nxt.reported_mask = block_r;
        block_nxt = block_r | mval_nokill;
      end
      CMD_UNBLOCK: begin
        res_nxt.reported_mask = block_r;
        block_nxt = block_r & ~mval_nokill;
      end
      CMD_SET_MASK: begin
        res_nxt.reported_mask = block_r;
        block_nxt = mval_nokill;
      end
      CMD_SUSPEND: begin
        res_nxt.reported_mask = block_r;
        stash_nxt   = block_r;
        stash_v_nxt = 1'b1;
        block_nxt   = mval_nokill;
      end
      CMD_DELIVER: begin
        pend_nxt = pend_r & ~sel.clear;
        if (sel.found) begin
          res_nxt.delivered_signal = sel.idx;
          if (((sel.onehot & hdl_vec) != '0) && ((sel.onehot & KILL_BIT) == '0)) begin
            // run the handler; frame mask is the stash if one is held
            res_nxt.outcome             = OC_HANDLER;
            res_nxt.handler_address_out = rd_entry;
            res_nxt.reported_mask       = stash_v_r ? stash_r : block_r;
            stash_v_nxt                 = 1'b0;
            block_nxt                   = block_r | rd_hmask | sel.onehot;
            tbl_we_revert               = rd_once;
          end else begin
            res_nxt.outcome = OC_TERMINATE;
          end
        end else if (stash_v_r) begin
          // nothing to deliver: leave suspend
          block_nxt   = stash_r;
          stash_v_nxt = 1'b0;
        end
      end
      CMD_RESTORE: begin
        res_nxt.reported_mask = block_r;
        block_nxt = item_r.mask_value;
      end
      default: begin
        res_nxt.status = STATUS_OK;
      end
    endcase
    res_nxt.wake_ready = ((pend_nxt & ~block_nxt) | (pend_nxt & KILL_BIT)) != '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fatal_r   <= '0;
      pend_r    <= '0;
      block_r   <= '0;
      stash_r   <= '0;
      stash_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) fatal_r <= cfg_wr_data;
      if (exec) begin
        pend_r    <= pend_nxt;
        block_r   <= block_nxt;
        stash_r   <= stash_nxt;
        stash_v_r <= stash_v_nxt;
      end
    end
  end

  // disposition table writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        kind_r[i]  <= KIND_DEFAULT;
        once_r[i]  <= 1'b0;
        ent_v_r[i] <= 1'b0;
      end
    end else if (exec) begin
      if (tbl_we_set) begin
        kind_r[tbl_idx]  <= item_r.action_kind;
        once_r[tbl_idx]  <= item_r.reset_on_delivery;
        ent_v_r[tbl_idx] <= 1'b1;
      end else if (tbl_we_revert) begin
        kind_r[tbl_idx] <= KIND_DEFAULT;
      end
    end
  end

  // wide table payload, qualified by the entry valid bits
  always_ff @(posedge clk) begin
    if (exec) begin
      if (tbl_we_set) begin
        hmask_r[tbl_idx] <= item_r.handler_mask_in;
        entry_r[tbl_idx] <= item_r.handler_address_in;
      end else if (tbl_we_revert) begin
        entry_r[tbl_idx] <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    iv_r && ov_r && !out_word.ready |=> iv_r)
    else $error("queued command lost while result stalled");

  a_suspend_stashes: assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd == CMD_SUSPEND |=> stash_v_r)
    else $error("suspend did not leave a valid stash");

  a_handler_self_block: assert property (@(posedge clk) disable iff (!rst_n)
    exec && res_nxt.outcome == OC_HANDLER |=> block_r[res_r.delivered_signal])
    else $error("handler delivery did not block its own signal");

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    sel.found |-> $onehot(sel.onehot))
    else $error("deliver pick is not one-hot");

  a_no_signal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && res_r.outcome != OC_NONE |-> res_r.delivered_signal != '0)
    else $error("signal zero delivered");

  a_kill_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (pend_nxt & KILL_BIT) != '0 |=> res_r.wake_ready)
    else $error("pending kill without wake");
`endif

endmodule

// ===== rtl/sdc_pick.sv =====
// Deliver picker: finds the lowest deliverable signal that stops the scan and
// the set of pending bits the scan consumes. Depends on sdc_pkg.
module sdc_pick import sdc_pkg::*; #(
  parameter int                  KILL_INDEX = 9,
  parameter logic [MAP_BITS-1:0] SCAN_MASK  = 32'hFFFF_FFFE
) (
  input  logic [MAP_BITS-1:0] pending,
  input  logic [MAP_BITS-1:0] block,
  input  logic [MAP_BITS-1:0] dflt_vec,
  input  logic [MAP_BITS-1:0] hdl_vec,
  input  logic [MAP_BITS-1:0] fatal_mask,
  output sel_t                sel
);

  localparam logic [MAP_BITS-1:0] KILL_BIT = MAP_BITS'(1) << KILL_INDEX;

  logic [MAP_BITS-1:0] dlv;
  logic [MAP_BITS-1:0] stop;
  logic [MAP_BITS-1:0] onehot;
  logic [MAP_BITS-1:0] upto;
  logic [SIG_W-1:0]    idx;

  // deliverable signals; kill ignores the mask
  assign dlv = ((pending & ~block) | (pending & KILL_BIT)) & SCAN_MASK;

  // a signal stops the scan if it terminates or runs a handler
  assign stop   = dlv & (KILL_BIT | (dflt_vec & fatal_mask) | hdl_vec);
  assign onehot = stop & (~stop + MAP_BITS'(1));

  // every deliverable signal at or below the chosen one is consumed; with no pick, all are
  assign upto = (stop != '0) ? (onehot | (onehot - MAP_BITS'(1))) : '1;

  // encode the one-hot pick
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAP_BITS; i++) begin
      if (onehot[i]) idx = idx | SIG_W'(i);
    end
  end

  assign sel.found  = (stop != '0);
  assign sel.idx    = idx;
  assign sel.onehot = onehot;
  assign sel.clear  = dlv & upto;

endmodule
